### src/iidreg_pkg.sv
package iidreg_pkg;

  localparam int unsigned IdW      = 16;
  localparam int unsigned NodeW    = 16;
  localparam int unsigned PairW    = 32;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic ACT_CONN   = 1'b0;
  localparam logic ACT_NEURON = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_INPUT_COUNT  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_OUTPUT_COUNT = 1'd1;

  localparam logic [CfgDataW-1:0] INPUT_COUNT_RST  = 8'd8;
  localparam logic [CfgDataW-1:0] OUTPUT_COUNT_RST = 8'd4;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_RESP  = 4'b1000
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic neuron;
  } mem_ctl_t;

endpackage

### src/iidreg_req_if.sv
interface iidreg_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [iidreg_pkg::NodeW-1:0]  src_node;
  logic [iidreg_pkg::NodeW-1:0]  dst_node;
  logic [iidreg_pkg::IdW-1:0]    conn_id;

  modport source (output valid, action, src_node, dst_node, conn_id, input ready);
  modport sink (input valid, action, src_node, dst_node, conn_id, output ready);
endinterface

### src/iidreg_rsp_if.sv
interface iidreg_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [iidreg_pkg::IdW-1:0]  assigned_id;
  logic                        newly_assigned;
  logic                        table_full;

  modport source (output valid, assigned_id, newly_assigned, table_full, input ready);
  modport sink (input valid, assigned_id, newly_assigned, table_full, output ready);
endinterface

### src/innovation_id_registry.sv
// Innovation id registry: returns the id of a connection (source, destination
// node pair) or of a neuron (keyed by connection id), assigning a new one on
// first sight.
// Channels: req_i takes one request per valid/ready handshake; rsp_o returns
// exactly one result per request, in order. cfg_we_i/cfg_idx_i/cfg_data_i
// write input_count (index 0) and output_count (index 1); the user must do so
// only while idle, and the block itself does not enforce it. A predefined
// input-to-output pair is answered from the CHECK state without a memory scan.
// Other keys are read from the key memory one per cycle; a scan ends at a hit,
// and a miss reads every learned key of that kind, then inserts the key or,
// with a full table, reports table_full. One request is in flight: req_i.ready
// is high only while idle, so a request holds the block until it is done.
// The result sits in an output register, so a new request is taken while a
// previous result waits; if rsp_o is still stalled when the next result is
// ready, the block holds it and stays busy until the output is taken.
// Reset clears both key counts and restores input_count 8, output_count 4;
// the memories themselves are not cleared, only entries below the count are
// ever read.
module innovation_id_registry #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  iidreg_req_if.sink                      req_i,
  iidreg_rsp_if.source                    rsp_o,
  input  logic                            cfg_we_i,
  input  logic [iidreg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [iidreg_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  iidreg_pkg::mem_ctl_t          mem_ctl;
  logic [AddrW-1:0]              rd_addr, wr_addr;
  logic [iidreg_pkg::PairW-1:0]  wdata, pair_rdata;
  logic [iidreg_pkg::IdW-1:0]    neu_rdata;

  iidreg_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .rsp          (rsp_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mem_ctl_o    (mem_ctl),
    .rd_addr_o    (rd_addr),
    .wr_addr_o    (wr_addr),
    .wdata_o      (wdata),
    .pair_rdata_i (pair_rdata),
    .neu_rdata_i  (neu_rdata)
  );

  iidreg_key_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (iidreg_pkg::PairW)
  ) u_pair_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_ctl.rd_en && !mem_ctl.neuron),
    .rd_addr_i (rd_addr),
    .rdata_o   (pair_rdata),
    .wr_en_i   (mem_ctl.wr_en && !mem_ctl.neuron),
    .wr_addr_i (wr_addr),
    .wdata_i   (wdata)
  );

  iidreg_key_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (iidreg_pkg::IdW)
  ) u_neu_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_ctl.rd_en && mem_ctl.neuron),
    .rd_addr_i (rd_addr),
    .rdata_o   (neu_rdata),
    .wr_en_i   (mem_ctl.wr_en && mem_ctl.neuron),
    .wr_addr_i (wr_addr),
    .wdata_i   (wdata[iidreg_pkg::IdW-1:0])
  );

endmodule

### src/iidreg_key_mem.sv
module iidreg_key_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/iidreg_ctrl.sv
module iidreg_ctrl #(
  parameter int unsigned TABLE_DEPTH = 256,
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH),
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  iidreg_req_if.sink                          req,
  iidreg_rsp_if.source                        rsp,
  input  logic                                cfg_we_i,
  input  logic [iidreg_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [iidreg_pkg::CfgDataW-1:0]     cfg_data_i,
  output iidreg_pkg::mem_ctl_t                mem_ctl_o,
  output logic [AddrW-1:0]                    rd_addr_o,
  output logic [AddrW-1:0]                    wr_addr_o,
  output logic [iidreg_pkg::PairW-1:0]        wdata_o,
  input  logic [iidreg_pkg::PairW-1:0]        pair_rdata_i,
  input  logic [iidreg_pkg::IdW-1:0]          neu_rdata_i
);

  iidreg_pkg::state_e state_q, state_d;

  logic                            action_q, action_d;
  logic [iidreg_pkg::PairW-1:0]    key_q, key_d;
  logic [iidreg_pkg::CfgDataW-1:0] in_cnt_q, out_cnt_q;
  logic [CntW-1:0]                 pair_cnt_q, pair_cnt_d;
  logic [CntW-1:0]                 neu_cnt_q, neu_cnt_d;
  logic [CntW-1:0]                 scan_idx_q, scan_idx_d;
  logic                            pend_q, pend_d;
  logic [AddrW-1:0]                pend_idx_q, pend_idx_d;
  logic [iidreg_pkg::IdW-1:0]      base_q, base_d;
  logic [iidreg_pkg::IdW-1:0]      res_id_q, res_id_d;
  logic                            res_new_q, res_new_d;
  logic                            res_full_q, res_full_d;
  logic                            out_vld_q, out_vld_d;
  logic [iidreg_pkg::IdW-1:0]      out_id_q, out_id_d;
  logic                            out_new_q, out_new_d;
  logic                            out_full_q, out_full_d;

  logic [iidreg_pkg::NodeW-1:0] src, dst;
  logic                         is_pre;
  logic [23:0]                  pre_prod;
  logic [iidreg_pkg::IdW-1:0]   pre_id, base_mul, base_add;
  logic [CntW-1:0]              cur_cnt;
  logic                         key_hit, rd_ok, scan_end, tbl_full;

  assign src = key_q[31:16];
  assign dst = key_q[15:0];

  assign is_pre = (action_q == iidreg_pkg::ACT_CONN)
               && (src < {8'd0, in_cnt_q})
               && (dst >= {8'd0, in_cnt_q})
               && ({1'b0, dst} < ({9'd0, in_cnt_q} + {9'd0, out_cnt_q}));
  assign pre_prod = {8'd0, src} * {16'd0, out_cnt_q};
  assign pre_id   = pre_prod[15:0] + (dst - {8'd0, in_cnt_q});
  assign base_mul = {8'd0, in_cnt_q} * {8'd0, out_cnt_q};
  assign base_add = {8'd0, in_cnt_q} + {8'd0, out_cnt_q};

  assign cur_cnt  = (action_q == iidreg_pkg::ACT_NEURON) ? neu_cnt_q : pair_cnt_q;
  assign key_hit  = pend_q && ((action_q == iidreg_pkg::ACT_NEURON)
                  ? (neu_rdata_i == key_q[15:0]) : (pair_rdata_i == key_q));
  assign rd_ok    = scan_idx_q < cur_cnt;
  assign scan_end = !pend_q && (scan_idx_q == cur_cnt);
  assign tbl_full = cur_cnt == CntW'(TABLE_DEPTH);

  assign req.ready         = state_q == iidreg_pkg::ST_IDLE;
  assign rsp.valid         = out_vld_q;
  assign rsp.assigned_id   = out_id_q;
  assign rsp.newly_assigned = out_new_q;
  assign rsp.table_full    = out_full_q;

  assign rd_addr_o = scan_idx_q[AddrW-1:0];
  assign wr_addr_o = cur_cnt[AddrW-1:0];
  assign wdata_o   = key_q;

  always_comb begin
    state_d    = state_q;
    action_d   = action_q;
    key_d      = key_q;
    pair_cnt_d = pair_cnt_q;
    neu_cnt_d  = neu_cnt_q;
    scan_idx_d = scan_idx_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    base_d     = base_q;
    res_id_d   = res_id_q;
    res_new_d  = res_new_q;
    res_full_d = res_full_q;
    out_vld_d  = out_vld_q && !rsp.ready;
    out_id_d   = out_id_q;
    out_new_d  = out_new_q;
    out_full_d = out_full_q;
    mem_ctl_o.rd_en  = 1'b0;
    mem_ctl_o.wr_en  = 1'b0;
    mem_ctl_o.neuron = action_q;

    unique case (state_q)
      iidreg_pkg::ST_IDLE: begin
        if (req.valid) begin
          action_d = req.action;
          key_d    = (req.action == iidreg_pkg::ACT_NEURON)
                   ? {16'd0, req.conn_id} : {req.src_node, req.dst_node};
          state_d  = iidreg_pkg::ST_CHECK;
        end
      end
      iidreg_pkg::ST_CHECK: begin
        if (is_pre) begin
          res_id_d   = pre_id;
          res_new_d  = 1'b0;
          res_full_d = 1'b0;
          state_d    = iidreg_pkg::ST_RESP;
        end else begin
          base_d     = (action_q == iidreg_pkg::ACT_NEURON) ? base_add : base_mul;
          scan_idx_d = '0;
          pend_d     = 1'b0;
          state_d    = iidreg_pkg::ST_SCAN;
        end
      end
      iidreg_pkg::ST_SCAN: begin
        if (key_hit) begin
          res_id_d   = base_q + iidreg_pkg::IdW'(pend_idx_q);
          res_new_d  = 1'b0;
          res_full_d = 1'b0;
          state_d    = iidreg_pkg::ST_RESP;
        end else if (scan_end) begin
          if (tbl_full) begin
            res_id_d   = '0;
            res_new_d  = 1'b0;
            res_full_d = 1'b1;
          end else begin
            mem_ctl_o.wr_en = 1'b1;
            res_id_d   = base_q + iidreg_pkg::IdW'(cur_cnt);
            res_new_d  = 1'b1;
            res_full_d = 1'b0;
            if (action_q == iidreg_pkg::ACT_NEURON) begin
              neu_cnt_d = neu_cnt_q + CntW'(1);
            end else begin
              pair_cnt_d = pair_cnt_q + CntW'(1);
            end
          end
          state_d = iidreg_pkg::ST_RESP;
        end else begin
          mem_ctl_o.rd_en = rd_ok;
          pend_d     = rd_ok;
          pend_idx_d = scan_idx_q[AddrW-1:0];
          scan_idx_d = scan_idx_q + CntW'(rd_ok);
        end
      end
      iidreg_pkg::ST_RESP: begin
        if (!out_vld_q || rsp.ready) begin
          out_vld_d  = 1'b1;
          out_id_d   = res_id_q;
          out_new_d  = res_new_q;
          out_full_d = res_full_q;
          state_d    = iidreg_pkg::ST_IDLE;
        end
      end
      default: state_d = iidreg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= iidreg_pkg::ST_IDLE;
      in_cnt_q   <= iidreg_pkg::INPUT_COUNT_RST;
      out_cnt_q  <= iidreg_pkg::OUTPUT_COUNT_RST;
      pair_cnt_q <= '0;
      neu_cnt_q  <= '0;
      scan_idx_q <= '0;
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pair_cnt_q <= pair_cnt_d;
      neu_cnt_q  <= neu_cnt_d;
      scan_idx_q <= scan_idx_d;
      pend_q     <= pend_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          iidreg_pkg::REG_INPUT_COUNT:  in_cnt_q  <= cfg_data_i;
          iidreg_pkg::REG_OUTPUT_COUNT: out_cnt_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    key_q      <= key_d;
    pend_idx_q <= pend_idx_d;
    base_q     <= base_d;
    res_id_q   <= res_id_d;
    res_new_q  <= res_new_d;
    res_full_q <= res_full_d;
    out_id_q   <= out_id_d;
    out_new_q  <= out_new_d;
    out_full_q <= out_full_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair_cnt_q <= CntW'(TABLE_DEPTH)) && (neu_cnt_q <= CntW'(TABLE_DEPTH)))
    else $error("entry count above table depth");

  a_wr_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl_o.wr_en |-> (state_q == iidreg_pkg::ST_SCAN) && !tbl_full && !mem_ctl_o.rd_en)
    else $error("table write outside a miss");

  a_pair_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair_cnt_q != $past(pair_cnt_q)) |->
      ($past(mem_ctl_o.wr_en) && !$past(mem_ctl_o.neuron)))
    else $error("pair count moved without insert");

  a_neu_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (neu_cnt_q != $past(neu_cnt_q)) |->
      ($past(mem_ctl_o.wr_en) && $past(mem_ctl_o.neuron)))
    else $error("neuron count moved without insert");

endmodule
